// ===== hdl/sdcd_pkg.sv =====
// Package for the SD host clock divider calculator.
// Holds widths, register map, reset values and the divider pipeline record.
// No dependencies; every other file of the block refers to it by scoped name.
package sdcd_pkg;

	// Field widths.
	localparam int unsigned FREQ_W  = 32;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned DIV_W   = 10;
	localparam int unsigned EXP_W   = 3;

	// One quotient bit is resolved per divider stage.
	localparam int unsigned DIV_STAGES = FREQ_W;

	// APB register map (word index taken from paddr bits above the byte offset).
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam logic REG_BASE_CLOCK  = 1'b0;
	localparam logic REG_PROG_DIV    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [FREQ_W-1:0] BASE_CLOCK_RESET = 32'd41666666;
	localparam logic              PROG_DIV_RESET   = 1'b0;

	// Divider limits.
	localparam logic [EXP_W-1:0]  MAX_EXPONENT  = 3'd7;
	localparam logic [FREQ_W-1:0] DIVIDER_FLOOR = 32'd2;

	// Record carried from one divider stage to the next.
	typedef struct packed {
		logic [FREQ_W-1:0] num;   // numerator bits still to be shifted in, MSB first
		logic [FREQ_W-1:0] div;   // divisor (the requested frequency)
		logic [FREQ_W-1:0] rem;   // partial remainder
		logic [FREQ_W-1:0] quo;   // quotient bits resolved so far
		logic              prog;  // programmable divider mode for this transaction
	} div_t;

endpackage

// ===== hdl/sdcd_if.sv =====
// Valid/ready channel interfaces of the SD host clock divider calculator.
// Request carries the frequency, response carries the packed divider field.
// Depends on sdcd_pkg for the field widths.
interface sdcd_req_if;
	logic                           valid;
	logic                           ready;
	logic [sdcd_pkg::FREQ_W-1:0]    freq_hz;

	modport source (output valid, output freq_hz, input ready);
	modport sink (input valid, input freq_hz, output ready);
endinterface

interface sdcd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sdcd_pkg::FIELD_W-1:0]   divider_field;

	modport source (output valid, output divider_field, input ready);
	modport sink (input valid, input divider_field, output ready);
endinterface

// ===== hdl/sd_host_clock_divider_calc.sv =====
// Top level of the SD host clock divider calculator.
// Depends on sdcd_pkg, sdcd_if, sdcd_div_stage and sdcd_encode.
//
// Usage:
//   Configure base_clock_hz (byte address 0) and programmable_divider
//   (byte address 4) over the APB port while no transaction is in flight;
//   pready is always high and reads return the register values.
//   Send a requested card clock in hertz on req (valid/ready). For each
//   request one transaction appears on rsp with the packed divider field:
//   divider bits 7..0 in bits 15..8, bits 9..8 in bits 7..6.
// Structure and throughput:
//   32 restoring divider stages, each resolving one quotient bit with one
//   33-bit subtract, followed by the encode stage that also serves as the
//   output register. One request is accepted every cycle unless every
//   stage is occupied behind a stalled rsp.
// Stalls and reset:
//   Each stage holds its content while the next one is full and blocked, so
//   empty stages keep filling while rsp is stalled; req.ready falls only
//   when every stage is occupied. Reset empties the pipeline and restores
//   the register reset values (41666666 Hz, power-of-two mode).
module sd_host_clock_divider_calc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdcd_pkg::PADDR_W-1:0]    paddr,
	input  logic [sdcd_pkg::PDATA_W-1:0]    pwdata,
	output logic [sdcd_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	sdcd_req_if.sink                        req,
	sdcd_rsp_if.source                      rsp
);

	logic [sdcd_pkg::FREQ_W-1:0]        base_clock_q;
	logic                               prog_q;
	logic                               reg_sel;
	logic                               wr_en;
	logic [sdcd_pkg::DIV_STAGES:0]      stage_valid;
	logic [sdcd_pkg::DIV_STAGES:0]      stage_ready;
	sdcd_pkg::div_t                     stage_data [sdcd_pkg::DIV_STAGES+1];

	// Configuration register writes.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_clock_q <= sdcd_pkg::BASE_CLOCK_RESET;
			prog_q       <= sdcd_pkg::PROG_DIV_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				sdcd_pkg::REG_BASE_CLOCK: base_clock_q <= pwdata;
				sdcd_pkg::REG_PROG_DIV:   prog_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		unique case (reg_sel)
			sdcd_pkg::REG_BASE_CLOCK: prdata = base_clock_q;
			sdcd_pkg::REG_PROG_DIV:   prdata = {31'd0, prog_q};
			default:                  prdata = '0;
		endcase
	end

	// Pipeline entry: numerator is the base clock, divisor the request.
	always_comb begin
		stage_data[0].num  = base_clock_q;
		stage_data[0].div  = req.freq_hz;
		stage_data[0].rem  = '0;
		stage_data[0].quo  = '0;
		stage_data[0].prog = prog_q;
	end
	assign stage_valid[0] = req.valid;
	assign req.ready      = stage_ready[0];

	// Restoring divider, one quotient bit per stage.
	for (genvar g = 0; g < sdcd_pkg::DIV_STAGES; g++) begin : g_div
		sdcd_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_data   (stage_data[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_data  (stage_data[g+1])
		);
	end

	// Divider field encoding and output register.
	sdcd_encode u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[sdcd_pkg::DIV_STAGES]),
		.in_ready  (stage_ready[sdcd_pkg::DIV_STAGES]),
		.in_data   (stage_data[sdcd_pkg::DIV_STAGES]),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_field (rsp.divider_field)
	);

`ifndef ASSERT_OFF
	// The pipeline only refuses requests when it is full behind a stalled output.
	a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (rsp.valid && !rsp.ready))
		else $error("request refused while the output was not blocked");

	// The low six bits of the field are always zero.
	a_low_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.divider_field[5:0] == 6'd0))
		else $error("divider field low bits not zero");

	// Power-of-two mode gives a single set bit of at least 2 and no high bits.
	a_legacy_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !prog_q) |->
		($onehot(rsp.divider_field[15:8]) && !rsp.divider_field[8]
		 && (rsp.divider_field[7:6] == 2'b00)))
		else $error("power-of-two divider field malformed");
`endif

endmodule

// ===== hdl/sdcd_div_stage.sv =====
// One stage of the restoring divider pipeline: resolves one quotient bit.
// Depends on sdcd_pkg for the stage record type.
module sdcd_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sdcd_pkg::div_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sdcd_pkg::div_t   out_data
);

	logic                           valid_s1;
	sdcd_pkg::div_t                 data_s1;
	logic [sdcd_pkg::FREQ_W:0]      shifted;
	logic [sdcd_pkg::FREQ_W:0]      diff;
	logic                           ge;
	sdcd_pkg::div_t                 next_data;

	// The stage takes a new transaction when empty or when its content moves on.
	assign in_ready = !valid_s1 || out_ready;

	// Shift in the next numerator bit and try to subtract the divisor.
	always_comb begin
		shifted = {in_data.rem, in_data.num[sdcd_pkg::FREQ_W-1]};
		diff    = shifted - {1'b0, in_data.div};
		ge      = shifted >= {1'b0, in_data.div};
		next_data      = in_data;
		next_data.num  = {in_data.num[sdcd_pkg::FREQ_W-2:0], 1'b0};
		next_data.rem  = ge ? diff[sdcd_pkg::FREQ_W-1:0] : shifted[sdcd_pkg::FREQ_W-1:0];
		next_data.quo  = {in_data.quo[sdcd_pkg::FREQ_W-2:0], ge};
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_data;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== hdl/sdcd_encode.sv =====
// Final stage: turns the ratio into the packed clock control divider field.
// Depends on sdcd_pkg for widths, limits and the stage record type.
module sdcd_encode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sdcd_pkg::div_t                 in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sdcd_pkg::FIELD_W-1:0]   out_field
);

	logic                           valid_s1;
	logic [sdcd_pkg::FIELD_W-1:0]   field_s1;
	logic [sdcd_pkg::FREQ_W-1:0]    ratio;
	logic [sdcd_pkg::FREQ_W-1:0]    ratio_m1;
	logic [sdcd_pkg::EXP_W-1:0]     exponent;
	logic [sdcd_pkg::DIV_W-1:0]     divider;
	logic [1:0]                     hi_bits;
	logic [sdcd_pkg::FIELD_W-1:0]   next_field;

	assign in_ready = !valid_s1 || out_ready;
	assign ratio    = in_data.quo;
	assign ratio_m1 = ratio - 32'd1;

	// Exponent is the top set bit of ratio minus one, clamped to the maximum.
	always_comb begin
		exponent = '0;
		if (|ratio_m1[sdcd_pkg::FREQ_W-1:7]) begin
			exponent = sdcd_pkg::MAX_EXPONENT;
		end else begin
			for (int i = 1; i < 7; i++) begin
				if (ratio_m1[i]) begin
					exponent = sdcd_pkg::EXP_W'(i);
				end
			end
		end
	end

	// Select the divider, apply the floor and pack the field.
	always_comb begin
		if (in_data.prog) begin
			divider = (ratio <= sdcd_pkg::DIVIDER_FLOOR) ?
				sdcd_pkg::DIV_W'(sdcd_pkg::DIVIDER_FLOOR) : ratio[sdcd_pkg::DIV_W-1:0];
			hi_bits = divider[9:8];
		end else begin
			divider = (exponent <= 3'd1) ?
				sdcd_pkg::DIV_W'(sdcd_pkg::DIVIDER_FLOOR) : (10'd1 << exponent);
			hi_bits = 2'b00;
		end
		next_field = {divider[7:0], hi_bits, 6'b000000};
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			field_s1 <= next_field;
		end
	end

	assign out_valid = valid_s1;
	assign out_field = field_s1;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for sd_host_clock_divider_calc: requests on the valid/ready
// channel, APB register setup between phases, divider fields checked against a prediction.
// Depends on sdcd_pkg, the sdcd_req_if / sdcd_rsp_if interfaces and the block's RTL.
`timescale 1ns / 100ps

// Keeps the live register copy and the queue of divider fields still owed by the block.
class divider_scoreboard;
	logic [sdcd_pkg::FREQ_W-1:0]  base_clock_hz;
	logic                         prog_mode;
	logic [sdcd_pkg::FIELD_W-1:0] owed_fields[$];
	int unsigned                  errors;

	function new();
		base_clock_hz = sdcd_pkg::BASE_CLOCK_RESET;
		prog_mode     = sdcd_pkg::PROG_DIV_RESET;
		errors        = 0;
	endfunction

	// Work out the field that an accepted request must produce.
	function void note_request(logic [sdcd_pkg::FREQ_W-1:0] freq);
		logic [31:0] ratio;
		logic [31:0] below;
		logic [31:0] divider;
		int unsigned top;
		// A zero request makes the divider answer all ones.
		ratio = (freq == 0) ? 32'hFFFF_FFFF : base_clock_hz / freq;
		below = ratio - 32'd1;
		top = 0;
		for (int b = 0; b < 32; b++) begin
			if (below[b])
				top = b;
		end
		if (top > 32'(sdcd_pkg::MAX_EXPONENT))
			top = 32'(sdcd_pkg::MAX_EXPONENT);
		divider = prog_mode ? ratio : (32'd1 << top);
		if (divider <= sdcd_pkg::DIVIDER_FLOOR)
			divider = sdcd_pkg::DIVIDER_FLOOR;
		owed_fields.push_back({divider[7:0], prog_mode ? divider[9:8] : 2'b00, 6'b0});
	endfunction

	// Compare one returned field with the oldest one owed.
	function void check_field(logic [sdcd_pkg::FIELD_W-1:0] got);
		logic [sdcd_pkg::FIELD_W-1:0] want;
		if (owed_fields.size() == 0) begin
			$error("divider_field 0x%04h arrived with no request outstanding", got);
			errors++;
		end else begin
			want = owed_fields.pop_front();
			if (got !== want) begin
				$error("divider_field mismatch: expected 0x%04h, actual 0x%04h", want, got);
				errors++;
			end
		end
	endfunction
endclass

module testbench;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam logic [sdcd_pkg::PADDR_W-1:0] ADDR_BASE_CLOCK = {sdcd_pkg::REG_BASE_CLOCK, 2'b00};
	localparam logic [sdcd_pkg::PADDR_W-1:0] ADDR_PROG_DIV   = {sdcd_pkg::REG_PROG_DIV, 2'b00};

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [sdcd_pkg::PADDR_W-1:0]  paddr;
	logic [sdcd_pkg::PDATA_W-1:0]  pwdata;
	logic [sdcd_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	int unsigned                   cycle_count;
	bit                            steady_flow;
	bit                            hold_output_request;
	divider_scoreboard             sb = new();

	sdcd_req_if req_ch ();
	sdcd_rsp_if rsp_ch ();

	sd_host_clock_divider_calc DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog on the whole run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sd_host_clock_divider_calc verification failed");
			$finish;
		end
	end

	// Every response transaction is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_field(rsp_ch.divider_field);
	end

	// Response side: random stalls, steady stretches, and one long hold-off on request.
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = steady_flow ? 0 : $urandom_range(0, 6);
			if (hold_output_request) begin
				hold_output_request = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// Write one register, then read it back; called at a falling edge or later.
	task automatic write_register(input logic [sdcd_pkg::PADDR_W-1:0] addr,
			input logic [31:0] value, input logic [31:0] readback);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback) begin
			$error("prdata mismatch at 0x%0h: expected 0x%08h, actual 0x%08h",
				addr, readback, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Program both registers and mirror them in the scoreboard.
	task automatic set_divider_config(input logic [31:0] base, input logic prog);
		write_register(ADDR_BASE_CLOCK, base, base);
		write_register(ADDR_PROG_DIV, {31'b0, prog}, {31'b0, prog});
		sb.base_clock_hz = base;
		sb.prog_mode     = prog;
	endtask

	// Offer one request after a random gap, or none in steady flow; returns at the falling edge after acceptance.
	task automatic send_request(input logic [31:0] freq);
		int unsigned gap;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.freq_hz <= freq;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(freq);
		@(negedge clk);
	endtask

	// Wait for every owed field, then let the pipeline settle.
	task automatic wait_drained();
		while (sb.owed_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Edge cases of the ratio around the current base clock.
	task automatic run_directed();
		logic [31:0] b;
		b = sb.base_clock_hz;
		@(negedge clk);
		send_request(32'd0);
		send_request(32'd1);
		send_request(32'hFFFF_FFFF);
		send_request(b);
		send_request(b + 32'd1);
		send_request(b / 2);
		send_request(b / 3);
		send_request(b / 128);
		send_request(b / 129);
		send_request(b / 1023);
		send_request(b / 1025);
		send_request(32'd400000);
		req_ch.valid <= 1'b0;
		wait_drained();
	endtask

	// Random request, mostly aimed at ratios the divider encoding cares about.
	function automatic logic [31:0] random_freq();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind <= 2)
			return $urandom;
		else if (kind <= 6)
			return sb.base_clock_hz / $urandom_range(1, 1100) + $urandom_range(0, 2);
		else if (kind == 7)
			return $urandom_range(1, 4096);
		else if (kind == 8)
			return 32'd1 << $urandom_range(0, 31);
		else
			return sb.base_clock_hz + $urandom_range(0, 3) - 32'd1;
	endfunction

	// Main sequence: reset, directed checks in both modes, then random phases.
	initial begin
		logic [31:0] phase_base[8];
		logic        phase_prog[8];
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.freq_hz      = '0;
		steady_flow         = 1'b0;
		hold_output_request = 1'b0;
		phase_base = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1,
			32'd200000000, $urandom, $urandom, 32'd0};
		phase_prog = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register reset values first, then the programmable mode.
		run_directed();
		set_divider_config(sdcd_pkg::BASE_CLOCK_RESET, 1'b1);
		run_directed();

		for (int p = 0; p < 8; p++) begin
			set_divider_config(phase_base[p], phase_prog[p]);
			if (p == 4)
				hold_output_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				steady_flow = ((i / 40) % 3 == 0);
				send_request(random_freq());
			end
			req_ch.valid <= 1'b0;
			steady_flow = 1'b0;
			wait_drained();
		end

		if (sb.errors == 0 && sb.owed_fields.size() == 0)
			$display("sd_host_clock_divider_calc verification clean");
		else begin
			if (sb.owed_fields.size() != 0)
				$error("%0d divider_field transactions never arrived", sb.owed_fields.size());
			$display("sd_host_clock_divider_calc verification failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/sdcd_pkg.sv
hdl/sdcd_if.sv
hdl/sdcd_div_stage.sv
hdl/sdcd_encode.sv
hdl/sd_host_clock_divider_calc.sv
test/testbench.sv
